// ===== sv/accel_tilt_calibrated_assert.svh =====
`ifndef ACCEL_TILT_CALIBRATED_ASSERT_SVH
`define ACCEL_TILT_CALIBRATED_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ATC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ATC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/atc_pkg.sv =====
package atc_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int COEF_BITS_DEF       = 21;
  localparam int ANGLE_FRAC_BITS_DEF = 8;

  localparam int FIELD_W = 21;
  localparam int REG_W   = 63;
  localparam int AT_FRAC = 20;
  localparam int ISQ_STEPS = 32;

  localparam logic [REG_W-1:0] ROW_X_RST = 63'd16777;
  localparam logic [REG_W-1:0] ROW_Y_RST = 63'd16777 << 21;
  localparam logic [REG_W-1:0] ROW_Z_RST = 63'd16777 << 42;
  localparam logic [REG_W-1:0] OFFS_RST  = '0;

  typedef enum logic [1:0] {
    REG_ROW_X   = 2'd0,
    REG_ROW_Y   = 2'd1,
    REG_ROW_Z   = 2'd2,
    REG_OFFSETS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] row_x;
    logic [REG_W-1:0] row_y;
    logic [REG_W-1:0] row_z;
    logic [REG_W-1:0] offsets;
  } cal_cfg_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } cal_vec_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } isq_t;

  // arctangent of 2^-i in degrees at 2^-20
  function automatic logic [25:0] atan_deg(input int i);
    logic [25:0] v;
    case (i)
      0:  v = 26'd47185920;
      1:  v = 26'd27855475;
      2:  v = 26'd14718068;
      3:  v = 26'd7471121;
      4:  v = 26'd3750058;
      5:  v = 26'd1876857;
      6:  v = 26'd938658;
      7:  v = 26'd469357;
      8:  v = 26'd234682;
      9:  v = 26'd117342;
      10: v = 26'd58671;
      11: v = 26'd29335;
      12: v = 26'd14668;
      13: v = 26'd7334;
      14: v = 26'd3667;
      15: v = 26'd1833;
      16: v = 26'd917;
      17: v = 26'd458;
      18: v = 26'd229;
      19: v = 26'd115;
      20: v = 26'd57;
      21: v = 26'd29;
      22: v = 26'd14;
      23: v = 26'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  // one digit of a restoring square root
  function automatic isq_t isq_step(input isq_t cur, input logic [1:0] pair);
    logic [35:0] r2;
    logic [35:0] trial;
    isq_t nxt;
    r2 = {cur.rem, pair};
    trial = {2'b00, cur.root, 2'b01};
    if (r2 >= trial) begin
      nxt.rem  = 34'(r2 - trial);
      nxt.root = {cur.root[30:0], 1'b1};
    end else begin
      nxt.rem  = r2[33:0];
      nxt.root = {cur.root[30:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

// ===== sv/accel_tilt_calibrated.sv =====
// channel   direction  handshake                 payload
// input     in         push / full               accel_x, accel_y, accel_z
// result    out        pop / empty               cal_x, cal_y, cal_z, pitch_deg, roll_deg
// config    in/out     APB psel/penable/pready   paddr, pwdata, prdata (regs at 8*i)
//
// One sample per clock sustained while the output queue has room. Data passes 2 calibration
// stages, the middle queue, then 3 + 32 + CORDIC_STEPS back stages (32 set by the square root
// digit loop) before the result reaches the output queue. Synchronous reset empties both queues.
// A stalled output only holds the back pipeline; the front keeps filling the
// middle queue until it is full, then full rises.
`include "accel_tilt_calibrated_assert.svh"

module accel_tilt_calibrated #(
  parameter int CORDIC_STEPS    = atc_pkg::CORDIC_STEPS_DEF,
  parameter int COEF_BITS       = atc_pkg::COEF_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = atc_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] cal_x,
  output logic signed [15:0] cal_y,
  output logic signed [15:0] cal_z,
  output logic [15:0]        pitch_deg,
  output logic [15:0]        roll_deg,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int MaxDeg = 180 << ANGLE_FRAC_BITS;

  atc_pkg::cal_cfg_t cfg;
  atc_pkg::cal_vec_t f_data;
  atc_pkg::cal_vec_t m_data;
  logic              f_push;
  logic              m_full;
  logic              m_empty;
  logic              m_pop;
  logic              b_push;
  logic [79:0]       b_data;
  logic              o_full;
  logic [79:0]       o_data;

  atc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  atc_front #(.COEF_BITS(COEF_BITS)) u_front (
    .clk, .rst, .push, .full, .accel_x, .accel_y, .accel_z, .cfg,
    .q_push(f_push), .q_data(f_data), .q_full(m_full)
  );

  atc_queue #(.WIDTH(48), .DEPTH(4)) u_mid (
    .clk, .rst, .push(f_push), .din(f_data), .full(m_full),
    .pop(m_pop), .dout(m_data), .empty(m_empty)
  );

  atc_back #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
    .clk, .rst, .in_valid(!m_empty), .in_data(m_data), .in_pop(m_pop),
    .out_push(b_push), .out_data(b_data), .out_full(o_full)
  );

  atc_queue #(.WIDTH(80), .DEPTH(4)) u_out (
    .clk, .rst, .push(b_push), .din(b_data), .full(o_full),
    .pop, .dout(o_data), .empty
  );

  assign cal_x     = o_data[79:64];
  assign cal_y     = o_data[63:48];
  assign cal_z     = o_data[47:32];
  assign pitch_deg = o_data[31:16];
  assign roll_deg  = o_data[15:0];

  `ATC_ASSERT_IMP(a_pitch_range, !empty, pitch_deg <= MaxDeg || MaxDeg > 65535, "pitch out of range")
  `ATC_ASSERT_IMP(a_reset_empty, $fell(rst), empty && m_empty, "queues not empty after reset")
  `ATC_ASSERT_IMP(a_full_cause, full, m_full, "front stalled with room in middle queue")
  `ATC_ASSERT_NXT(a_no_phantom, empty && !b_push, empty, "result appeared without a back beat")

endmodule

// ===== sv/atc_queue.sv =====
module atc_queue #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== sv/atc_cfg.sv =====
module atc_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output atc_pkg::cal_cfg_t   cfg
);

  atc_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = atc_pkg::reg_idx_t'(paddr[4:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_x   <= atc_pkg::ROW_X_RST;
      cfg.row_y   <= atc_pkg::ROW_Y_RST;
      cfg.row_z   <= atc_pkg::ROW_Z_RST;
      cfg.offsets <= atc_pkg::OFFS_RST;
    end else if (wr) begin
      case (idx)
        atc_pkg::REG_ROW_X:   cfg.row_x   <= pwdata[62:0];
        atc_pkg::REG_ROW_Y:   cfg.row_y   <= pwdata[62:0];
        atc_pkg::REG_ROW_Z:   cfg.row_z   <= pwdata[62:0];
        atc_pkg::REG_OFFSETS: cfg.offsets <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      atc_pkg::REG_ROW_X:   prdata = {1'b0, cfg.row_x};
      atc_pkg::REG_ROW_Y:   prdata = {1'b0, cfg.row_y};
      atc_pkg::REG_ROW_Z:   prdata = {1'b0, cfg.row_z};
      atc_pkg::REG_OFFSETS: prdata = {1'b0, cfg.offsets};
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== sv/atc_front.sv =====
module atc_front #(
  parameter int COEF_BITS = atc_pkg::COEF_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  atc_pkg::cal_cfg_t  cfg,
  output logic               q_push,
  output atc_pkg::cal_vec_t  q_data,
  input  logic               q_full
);

  logic                v1;
  logic                v2;
  logic                en;
  logic signed [36:0]  prod [3][3];   // [output axis][input axis]
  logic signed [15:0]  ain [3];
  logic [62:0]         rows [3];
  logic signed [15:0]  cal_next [3];

  assign en     = !(v2 && q_full);
  assign full   = !en;
  assign q_push = v2;

  assign ain[0]  = accel_x;
  assign ain[1]  = accel_y;
  assign ain[2]  = accel_z;
  assign rows[0] = cfg.row_x;
  assign rows[1] = cfg.row_y;
  assign rows[2] = cfg.row_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= push;
      v2 <= v1;
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_out
    for (genvar k = 0; k < 3; k++) begin : g_in
      logic signed [COEF_BITS-1:0] gain;
      assign gain = rows[k][21*j +: COEF_BITS];
      always_ff @(posedge clk) begin
        if (en) begin
          prod[j][k] <= 37'(ain[k] * gain);
        end
      end
    end

    logic signed [20:0] offs;
    logic signed [39:0] acc;
    logic signed [27:0] shifted;
    assign offs = cfg.offsets[21*j +: 21];
    always_comb begin
      acc = 40'(prod[j][0]) + 40'(prod[j][1]) + 40'(prod[j][2])
          + (40'(offs) <<< 8) + 40'sd2048;
      shifted = 28'(acc >>> 12);
      if (shifted > 28'sd32767) begin
        cal_next[j] = 16'sd32767;
      end else if (shifted < -28'sd32768) begin
        cal_next[j] = -16'sd32768;
      end else begin
        cal_next[j] = shifted[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_data.x <= cal_next[0];
      q_data.y <= cal_next[1];
      q_data.z <= cal_next[2];
    end
  end

endmodule

// ===== sv/atc_back.sv =====
module atc_back #(
  parameter int CORDIC_STEPS    = atc_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = atc_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  atc_pkg::cal_vec_t in_data,
  output logic              in_pop,
  output logic              out_push,
  output logic [79:0]       out_data,
  input  logic              out_full
);

  localparam int N     = CORDIC_STEPS;
  localparam int ISQ   = atc_pkg::ISQ_STEPS;
  localparam int Depth = 3 + ISQ + N;
  localparam int Sh    = atc_pkg::AT_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [29:0] Deg90  = 30'sd90 <<< atc_pkg::AT_FRAC;
  localparam logic [27:0]        Half   = 28'd1 << (Sh - 1);

  logic                en;
  logic [Depth-1:0]    vld;
  atc_pkg::cal_vec_t   cal_pipe [Depth];

  logic [30:0]         sq [3];
  logic [31:0]         sum [2];        // lane 0 pitch, lane 1 roll
  atc_pkg::isq_t       isq [2][ISQ];
  logic [31:0]         rad [2][ISQ];
  logic signed [35:0]  cx [2][N];
  logic signed [35:0]  cy [2][N];
  logic signed [28:0]  cz [2][N];
  logic                czz [2][N];
  logic [15:0]         deg [2];

  assign en       = !(vld[Depth-1] && out_full);
  assign in_pop   = en && in_valid;
  assign out_push = vld[Depth-1];
  assign out_data = {cal_pipe[Depth-1].x, cal_pipe[Depth-1].y, cal_pipe[Depth-1].z,
                     deg[0], deg[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cal_pipe[0] <= in_data;
      for (int s = 1; s < Depth; s++) begin
        cal_pipe[s] <= cal_pipe[s-1];
      end
    end
  end

  // squares, then the two magnitude sums
  logic signed [31:0] sqf [3];
  assign sqf[0] = in_data.x * in_data.x;
  assign sqf[1] = in_data.y * in_data.y;
  assign sqf[2] = in_data.z * in_data.z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        sq[a] <= sqf[a][30:0];
      end
      sum[0] <= 32'(sq[1]) + 32'(sq[2]);
      sum[1] <= 32'(sq[0]) + 32'(sq[2]);
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    // square root of sum * 2^32, one result bit per stage
    for (genvar i = 0; i < ISQ; i++) begin : g_isq
      atc_pkg::isq_t cur;
      logic [31:0]   rin;
      if (i == 0) begin : g_first
        assign cur = '0;
        assign rin = sum[l];
      end else begin : g_rest
        assign cur = isq[l][i-1];
        assign rin = rad[l][i-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          isq[l][i] <= atc_pkg::isq_step(cur, rin[31:30]);
          rad[l][i] <= {rin[29:0], 2'b00};
        end
      end
    end

    // vectoring CORDIC, one iteration per stage
    for (genvar k = 0; k < N; k++) begin : g_cordic
      logic signed [35:0] xi, yi, xs, ys;
      logic signed [28:0] zi;
      logic               zzi;
      if (k == 0) begin : g_first
        logic signed [15:0] num;
        assign num = (l == 0) ? cal_pipe[ISQ+1].x : cal_pipe[ISQ+1].y;
        assign xi  = 36'(isq[l][ISQ-1].root);
        assign yi  = 36'(num) <<< 16;
        assign zi  = '0;
        assign zzi = (isq[l][ISQ-1].root == '0) && (num == '0);
      end else begin : g_rest
        assign xi  = cx[l][k-1];
        assign yi  = cy[l][k-1];
        assign zi  = cz[l][k-1];
        assign zzi = czz[l][k-1];
      end
      assign xs = xi >>> k;
      assign ys = yi >>> k;
      always_ff @(posedge clk) begin
        if (en) begin
          czz[l][k] <= zzi;
          if (!yi[35]) begin
            cx[l][k] <= xi + ys;
            cy[l][k] <= yi - xs;
            cz[l][k] <= zi + 29'(atc_pkg::atan_deg(k));
          end else begin
            cx[l][k] <= xi - ys;
            cy[l][k] <= yi + xs;
            cz[l][k] <= zi - 29'(atc_pkg::atan_deg(k));
          end
        end
      end
    end

    // offset, clamp to the half turn, round to the output grid
    logic signed [29:0] zd;
    logic [27:0]        zc;
    logic [27:0]        rnd;
    logic [15:0]        deg_next;
    always_comb begin
      zd = (czz[l][N-1] ? 30'sd0 : 30'(cz[l][N-1])) + Deg90;
      if (zd < 0) begin
        zc = '0;
      end else if (zd > (Deg90 <<< 1)) begin
        zc = 28'(Deg90 <<< 1);
      end else begin
        zc = zd[27:0];
      end
      rnd = (zc + Half) >> Sh;
      deg_next = (rnd > 28'd65535) ? 16'hFFFF : rnd[15:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        deg[l] <= deg_next;
      end
    end
  end

endmodule
